// ===== design/bfps_pkg.sv =====
// bfps_pkg: shared constants, types and helper functions for the byte fifo
// with pattern search; no dependencies
`timescale 1ns / 1ps

package bfps_pkg;

  // storage geometry
  localparam int DEPTH       = 256;
  localparam int MAX_PATTERN = 16;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH + 1);

  // field widths fixed by the interface
  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int PEEK_W     = 8;
  localparam int OFFSET_W   = 9;
  localparam int RANGE_W    = 9;
  localparam int LEN_W      = 5;
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // pattern position counter, holds 0 to MAX_PATTERN
  localparam int K_W = $clog2(MAX_PATTERN + 1);

  // width of window arithmetic, wide enough for sums up to twice the depth
  localparam int CALC_W = ((FILL_W > OFFSET_W) ? FILL_W : OFFSET_W) + 2;

  // subtract steps needed to bring rp + distance back below the depth
  localparam int WRAP_STEPS =
    (DEPTH - 1 + ((DEPTH > 255) ? DEPTH : 255)) / DEPTH;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [CALC_W-1:0] calc_t;
  typedef logic [K_W-1:0]    k_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SEARCH = 3'd3,
    OP_PEEK   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW   = 3'd0,
    CFG_PATTERN_HIGH  = 3'd1,
    CFG_PATTERN_LEN   = 3'd2,
    CFG_SEARCH_OFFSET = 3'd3,
    CFG_SEARCH_RANGE  = 3'd4,
    CFG_IGNORE_ZERO   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_ADDR,
    S_CMP
  } state_t;

  typedef struct packed {
    logic [PAT_BYTES*BYTE_W-1:0] pattern;
    logic [LEN_W-1:0]            pattern_len;
    logic [OFFSET_W-1:0]         search_offset;
    logic [RANGE_W-1:0]          search_range;
    logic                        ignore_zero;
  } cfg_t;

  typedef struct packed {
    logic              we;
    ptr_t              waddr;
    logic [BYTE_W-1:0] wdata;
    ptr_t              raddr;
  } mem_req_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // reduce a pointer-plus-distance sum modulo the depth
  function automatic ptr_t mod_depth(input calc_t s);
    calc_t v;
    v = s;
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (v >= CALC_W'(DEPTH)) begin
        v = v - CALC_W'(DEPTH);
      end
    end
    return v[PTR_W-1:0];
  endfunction

endpackage

// ===== design/bfps_cfg.sv =====
// bfps_cfg: search configuration registers behind a valid/ready write channel
// depends on bfps_pkg
`timescale 1ns / 1ps

module bfps_cfg
  import bfps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic write_en;

  assign cfg_ready = 1'b1;
  assign write_en  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern       <= '0;
      cfg.pattern_len   <= '0;
      cfg.search_offset <= '0;
      cfg.search_range  <= RANGE_W'(256);
      cfg.ignore_zero   <= 1'b1;
    end else if (write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LOW:   cfg.pattern[CFG_DATA_W-1:0] <= cfg_data;
        CFG_PATTERN_HIGH:  cfg.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        CFG_PATTERN_LEN:   cfg.pattern_len <= cfg_data[LEN_W-1:0];
        CFG_SEARCH_OFFSET: cfg.search_offset <= cfg_data[OFFSET_W-1:0];
        CFG_SEARCH_RANGE:  cfg.search_range <= cfg_data[RANGE_W-1:0];
        CFG_IGNORE_ZERO:   cfg.ignore_zero <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bfps_mem.sv =====
// bfps_mem: ring byte store, one write port and one registered read port
// depends on bfps_pkg
`timescale 1ns / 1ps

module bfps_mem
  import bfps_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
    rdata <= store[req.raddr];
  end

endmodule

// ===== design/bfps_ctrl.sv =====
// bfps_ctrl: pointers, fill count, operation decode and the search sequencer
// depends on bfps_pkg; drives bfps_mem through a mem_req_t
`timescale 1ns / 1ps

module bfps_ctrl
  import bfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [BYTE_W-1:0] data_in,
  input  logic [PEEK_W-1:0] peek_offset,
  input  cfg_t              cfg,
  output mem_req_t          mem_req,
  input  logic [BYTE_W-1:0] mem_rdata,
  output logic              done,
  output logic              ok,
  output logic [BYTE_W-1:0] data_out,
  output logic [FILL_W-1:0] fill_level,
  output logic              is_empty
);

  state_t state, state_next;
  ptr_t   wp, wp_next, rp, rp_next;
  fill_t  fill, fill_next;
  logic   done_next;
  logic   res_ok, res_ok_next;
  logic   res_mem, res_mem_next;
  ptr_t   win_ptr, win_ptr_next;
  ptr_t   byte_ptr, byte_ptr_next;
  fill_t  pos, pos_next, pos_last, pos_last_next;
  k_t     k, k_next;

  logic                 accept;
  op_t                  op;
  k_t                   len;
  calc_t                off_x, len_x, fill_x, room, rng, need, last_a, last_b;
  logic                 fail;
  logic [BYTE_W-1:0]    pat_byte;
  logic [PAT_IDX_W-1:0] pat_idx;
  logic                 match;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign op     = op_t'(operation);

  // pattern length saturates at the longest supported pattern
  assign len = (cfg.pattern_len > LEN_W'(MAX_PATTERN)) ? K_W'(MAX_PATTERN)
                                                       : K_W'(cfg.pattern_len);

  // window limits
  assign off_x  = CALC_W'(cfg.search_offset);
  assign len_x  = CALC_W'(len);
  assign fill_x = CALC_W'(fill);
  assign room   = CALC_W'(DEPTH) - off_x;
  assign rng    = (CALC_W'(cfg.search_range) < room) ? CALC_W'(cfg.search_range)
                                                     : room;
  assign need   = off_x + len_x;
  assign last_a = fill_x - need;
  assign last_b = rng - len_x;
  assign fail   = (off_x > CALC_W'(DEPTH)) || (rng < len_x) || (fill_x < need);

  assign pat_idx  = PAT_IDX_W'(k);
  assign pat_byte = cfg.pattern[pat_idx*BYTE_W +: BYTE_W];
  assign match    = (mem_rdata == pat_byte) || (cfg.ignore_zero && pat_byte == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    fill_next     = fill;
    done_next     = 1'b0;
    res_ok_next   = res_ok;
    res_mem_next  = res_mem;
    win_ptr_next  = win_ptr;
    byte_ptr_next = byte_ptr;
    pos_next      = pos;
    pos_last_next = pos_last;
    k_next        = k;
    mem_req.we    = 1'b0;
    mem_req.waddr = wp;
    mem_req.wdata = data_in;
    mem_req.raddr = byte_ptr;

    unique case (state)
      S_IDLE: begin
        if (op == OP_POP) begin
          mem_req.raddr = rp;
        end else begin
          mem_req.raddr = mod_depth(CALC_W'(rp) + CALC_W'(peek_offset));
        end
        if (accept) begin
          done_next    = 1'b1;
          res_ok_next  = 1'b0;
          res_mem_next = 1'b0;
          unique case (op)
            OP_PUSH: begin
              if (fill != FILL_W'(DEPTH)) begin
                mem_req.we  = 1'b1;
                wp_next     = next_ptr(wp);
                fill_next   = fill + 1'b1;
                res_ok_next = 1'b1;
              end
            end
            OP_POP: begin
              if (fill != '0) begin
                rp_next      = next_ptr(rp);
                fill_next    = fill - 1'b1;
                res_ok_next  = 1'b1;
                res_mem_next = 1'b1;
              end
            end
            OP_CLEAR: begin
              wp_next     = '0;
              rp_next     = '0;
              fill_next   = '0;
              res_ok_next = 1'b1;
            end
            OP_SEARCH: begin
              done_next  = 1'b0;
              state_next = S_SETUP;
            end
            OP_PEEK: begin
              res_ok_next  = 1'b1;
              res_mem_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        res_mem_next = 1'b0;
        if (fail) begin
          done_next   = 1'b1;
          res_ok_next = 1'b0;
          state_next  = S_IDLE;
        end else if (len == '0) begin
          done_next   = 1'b1;
          res_ok_next = 1'b1;
          state_next  = S_IDLE;
        end else begin
          // offset is at most the depth here, one wrap is enough
          win_ptr_next  = mod_depth(CALC_W'(rp) + off_x);
          byte_ptr_next = mod_depth(CALC_W'(rp) + off_x);
          pos_next      = '0;
          pos_last_next = (last_a < last_b) ? last_a[FILL_W-1:0] : last_b[FILL_W-1:0];
          k_next        = '0;
          state_next    = S_ADDR;
        end
      end
      S_ADDR: begin
        mem_req.raddr = byte_ptr;
        state_next    = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          if (k + 1'b1 == len) begin
            done_next   = 1'b1;
            res_ok_next = 1'b1;
            state_next  = S_IDLE;
          end else begin
            k_next        = k + 1'b1;
            byte_ptr_next = next_ptr(byte_ptr);
            state_next    = S_ADDR;
          end
        end else if (pos == pos_last) begin
          done_next   = 1'b1;
          res_ok_next = 1'b0;
          state_next  = S_IDLE;
        end else begin
          // slide the window by one byte and restart the compare
          win_ptr_next  = next_ptr(win_ptr);
          byte_ptr_next = next_ptr(win_ptr);
          pos_next      = pos + 1'b1;
          k_next        = '0;
          state_next    = S_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
      done <= 1'b0;
    end else begin
      wp   <= wp_next;
      rp   <= rp_next;
      fill <= fill_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    res_ok   <= res_ok_next;
    res_mem  <= res_mem_next;
    win_ptr  <= win_ptr_next;
    byte_ptr <= byte_ptr_next;
    pos      <= pos_next;
    pos_last <= pos_last_next;
    k        <= k_next;
  end

  // read data lands in the cycle after the pop or peek beat
  assign ok         = res_ok;
  assign data_out   = res_mem ? mem_rdata : '0;
  assign fill_level = fill;
  assign is_empty   = (fill == '0);

`ifndef ASSERT_OFF
  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    mod_depth(CALC_W'(rp) + CALC_W'(fill)) == wp)
    else $error("read pointer plus fill does not meet write pointer");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill count beyond depth");

  a_write_on_push: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_IDLE && start && fill != FILL_W'(DEPTH)))
    else $error("store written outside an accepted push");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state == S_SETUP) || $past(state == S_CMP)))
    else $error("result strobe without an item behind it");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (k < len && pos <= pos_last))
    else $error("search counters out of window");
`endif

endmodule

// ===== design/byte_fifo_with_pattern_search.sv =====
// byte_fifo_with_pattern_search: top level, ring byte fifo with pattern search
// depends on bfps_pkg, bfps_cfg, bfps_mem, bfps_ctrl
`timescale 1ns / 1ps

// A circular fifo of 256 bytes that takes one operation per beat: push, pop,
// clear, peek or search. An operation is taken at a clock edge where start is
// high and busy is low; its result shows on ok, data_out, fill_level and
// is_empty for exactly one cycle, marked by done, and must be captured then:
// there is no way to hold it off. For push, pop, clear and peek the result
// comes the cycle after the beat, and busy stays low, so a new one of these
// can be issued every cycle. Search raises busy: a setup state works out the
// window, then each compared byte takes an address state and a compare state
// on the single read port of the store. The worst case is a 16-byte pattern
// that fails on its last byte at each of the 241 start positions of a full
// window. After reset the block is ready at once; the store has no clearing
// pass, so a peek of a byte never pushed returns undefined data.
// Configuration writes are always accepted and should only be issued while
// no operation is in flight.

module byte_fifo_with_pattern_search
  import bfps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // operation channel
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       operation,
  input  logic [BYTE_W-1:0]     data_in,
  input  logic [PEEK_W-1:0]     peek_offset,
  // result beat
  output logic                  done,
  output logic                  ok,
  output logic [BYTE_W-1:0]     data_out,
  output logic [FILL_W-1:0]     fill_level,
  output logic                  is_empty,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  // pattern, window and wildcard settings
  bfps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte store, read data registered
  bfps_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // pointers, fill and the search walk
  bfps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .data_in     (data_in),
    .peek_offset (peek_offset),
    .cfg         (cfg),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .done        (done),
    .ok          (ok),
    .data_out    (data_out),
    .fill_level  (fill_level),
    .is_empty    (is_empty)
  );

endmodule

// ===== tb/tb_byte_fifo_with_pattern_search.sv =====
// tb_byte_fifo_with_pattern_search: self-checking bench for the ring byte fifo with pattern search
// directed and random operation beats, scoreboard against an in-bench ring/search predictor
// depends on bfps_pkg and byte_fifo_with_pattern_search
`timescale 1ns / 1ps

module tb_byte_fifo_with_pattern_search;
  import bfps_pkg::*;

  // run shape
  localparam int STEADY_ITEMS = 45;      // beats per mixed phase
  localparam int NUM_PHASES   = 16;
  localparam int FILL_PHASE   = 1;
  localparam int DRAIN_PHASE  = 9;
  // quiet limit, above the longest search plus the longest sender gap
  localparam int STALL_LIMIT  = 40000;

  // operation codes with no function, the block must answer them with ok 0
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  // two copies of the ring: one walked by the stimulus planner so that peeks
  // only land on bytes that were pushed at some point, one walked at each
  // accepted beat to produce the expected results
  localparam int PLAN   = 0;
  localparam int SHADOW = 1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] din;
    logic [PEEK_W-1:0] poff;
  } fifo_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic              empty;
  } fifo_resp_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       operation   = '0;
  logic [BYTE_W-1:0]     data_in     = '0;
  logic [PEEK_W-1:0]     peek_offset = '0;
  logic                  done;
  logic                  ok;
  logic [BYTE_W-1:0]     data_out;
  logic [FILL_W-1:0]     fill_level;
  logic                  is_empty;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  byte_fifo_with_pattern_search dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .data_in     (data_in),
    .peek_offset (peek_offset),
    .done        (done),
    .ok          (ok),
    .data_out    (data_out),
    .fill_level  (fill_level),
    .is_empty    (is_empty),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ring state, indexed by copy
  logic [BYTE_W-1:0] ring_mem  [2][DEPTH];
  bit                ring_seen [2][DEPTH];   // entry has been pushed at least once
  int                ring_wr   [2];
  int                ring_rd   [2];
  int                ring_fill [2];

  // search settings as last written to the block
  logic [63:0]         pat_lo;
  logic [63:0]         pat_hi;
  logic [LEN_W-1:0]    pat_len;
  logic [OFFSET_W-1:0] win_offset;
  logic [RANGE_W-1:0]  win_range;
  logic                skip_zero;

  fifo_cmd_t  op_backlog[$];        // beats planned but not yet presented
  fifo_resp_t awaited_results[$];   // expected result beats, oldest first
  fifo_cmd_t  cur_cmd;
  fifo_cmd_t  next_cmd;
  fifo_resp_t want;
  int         planned_count  = 0;
  int         accepted_count = 0;
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  int         gap_left       = 0;
  bit         no_gaps        = 1'b0;

  // single scan of the window: start offset past the read pointer, range
  // clipped to the room left below the depth, positions limited by the bytes actually held
  function automatic logic pattern_in_window(int who);
    int len;
    int rng;
    int last;
    int idx;
    logic [8*PAT_BYTES-1:0] pat;
    logic [BYTE_W-1:0] p;
    logic hit;
    pat = {pat_hi, pat_lo};
    len = int'(pat_len);
    if (len > MAX_PATTERN) len = MAX_PATTERN;   // oversize length saturates
    rng = int'(win_range);
    if (int'(win_offset) > DEPTH) return 1'b0;
    if (DEPTH - int'(win_offset) < rng) rng = DEPTH - int'(win_offset);
    if (rng < len) return 1'b0;
    if (ring_fill[who] < int'(win_offset) + len) return 1'b0;
    last = ring_fill[who] - (int'(win_offset) + len);
    if (last > rng - len) last = rng - len;
    for (int pos = 0; pos <= last; pos++) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        p = pat[8*k +: 8];
        idx = (ring_rd[who] + int'(win_offset) + pos + k) % DEPTH;
        // a zero pattern byte is a wildcard when skip_zero is set
        if (ring_mem[who][idx] != p && !(skip_zero && p == '0)) hit = 1'b0;
      end
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one operation to a ring copy and return its result beat
  function automatic fifo_resp_t ring_apply(int who, fifo_cmd_t c);
    fifo_resp_t r;
    r = '0;
    case (c.op)
      OP_PUSH: begin
        // full: byte dropped, nothing moves
        if (ring_fill[who] < DEPTH) begin
          ring_mem[who][ring_wr[who]] = c.din;
          ring_seen[who][ring_wr[who]] = 1'b1;
          ring_wr[who] = (ring_wr[who] + 1) % DEPTH;
          ring_fill[who]++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        // empty: ok 0 and data 0
        if (ring_fill[who] > 0) begin
          r.data = ring_mem[who][ring_rd[who]];
          ring_rd[who] = (ring_rd[who] + 1) % DEPTH;
          ring_fill[who]--;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        // pointers reset, stored bytes stay
        ring_wr[who] = 0;
        ring_rd[who] = 0;
        ring_fill[who] = 0;
        r.ok = 1'b1;
      end
      OP_SEARCH: r.ok = pattern_in_window(who);
      OP_PEEK: begin
        // may read beyond the fill
        r.data = ring_mem[who][(ring_rd[who] + int'(c.poff)) % DEPTH];
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.fill = FILL_W'(ring_fill[who]);
    r.empty = (ring_fill[who] == 0);
    return r;
  endfunction

  // sender idle time after a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // peek distance that lands on an entry already pushed, -1 when there is none
  function automatic int peek_target();
    int off;
    for (int t = 0; t < 8; t++) begin
      off = $urandom_range(DEPTH - 1);
      if (ring_seen[PLAN][(ring_rd[PLAN] + off) % DEPTH]) return off;
    end
    off = $urandom_range(DEPTH - 1);
    for (int t = 0; t < DEPTH; t++) begin
      if (ring_seen[PLAN][(ring_rd[PLAN] + off + t) % DEPTH]) return (off + t) % DEPTH;
    end
    return -1;
  endfunction

  task automatic queue_cmd(input fifo_cmd_t c);
    op_backlog.push_back(c);
    void'(ring_apply(PLAN, c));
    planned_count++;
  endtask

  task automatic queue_simple(input logic [OP_W-1:0] op);
    queue_cmd({op, BYTE_W'($urandom), PEEK_W'($urandom)});
  endtask

  task automatic queue_peek();
    int off;
    off = peek_target();
    if (off >= 0) queue_cmd({OP_PEEK, BYTE_W'($urandom), PEEK_W'(off)});
  endtask

  // random beat with given push and pop weights, the rest spread over
  // peek, search, clear and the unused codes
  task automatic queue_random(int w_push, int w_pop);
    fifo_cmd_t c;
    int r;
    int off;
    c.din = BYTE_W'($urandom);
    c.poff = PEEK_W'($urandom);
    r = $urandom_range(w_push + w_pop + 29);
    if (r < w_push) c.op = OP_PUSH;
    else if (r < w_push + w_pop) c.op = OP_POP;
    else if (r < w_push + w_pop + 14) c.op = OP_PEEK;
    else if (r < w_push + w_pop + 24) c.op = OP_SEARCH;
    else if (r < w_push + w_pop + 26) c.op = OP_CLEAR;
    else c.op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    if (c.op == OP_PEEK) begin
      off = peek_target();
      if (off < 0) c.op = OP_POP;
      else c.poff = PEEK_W'(off);
    end
    queue_cmd(c);
  endtask

  // block is idle once every planned beat went in and every result came back
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_count != planned_count || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PATTERN_LOW:   pat_lo = val;
      CFG_PATTERN_HIGH:  pat_hi = val;
      CFG_PATTERN_LEN:   pat_len = val[LEN_W-1:0];
      CFG_SEARCH_OFFSET: win_offset = val[OFFSET_W-1:0];
      CFG_SEARCH_RANGE:  win_range = val[RANGE_W-1:0];
      CFG_IGNORE_ZERO:   skip_zero = val[0];
      default: ;
    endcase
  endtask

  // new search settings for a phase; the pattern is mostly lifted from the
  // bytes held right now so that searches hit as well as miss, and some
  // phases pin a register to an extreme
  task automatic program_search(int ph);
    logic [8*PAT_BYTES-1:0] pat;
    logic [LEN_W-1:0]       len;
    logic [OFFSET_W-1:0]    off;
    logic [RANGE_W-1:0]     rng;
    logic [BYTE_W-1:0]      b;
    logic                   ign;
    int                     s;
    int                     r;
    ign = (ph % 2 == 1);
    s = (ring_fill[PLAN] > 0) ? $urandom_range(ring_fill[PLAN] - 1) : 0;

    if ($urandom_range(99) < 60) begin
      for (int k = 0; k < PAT_BYTES; k++) begin
        b = ring_seen[PLAN][(ring_rd[PLAN] + s + k) % DEPTH] ?
            ring_mem[PLAN][(ring_rd[PLAN] + s + k) % DEPTH] : BYTE_W'($urandom);
        if (ign && $urandom_range(3) == 0) b = '0;
        pat[8*k +: 8] = b;
      end
    end else begin
      pat = {$urandom, $urandom, $urandom, $urandom};
    end
    if (ph == 11) pat = '1;
    if (ph == 13) pat = '0;

    r = $urandom_range(99);
    if (r < 50) len = LEN_W'($urandom_range(1, 4));
    else if (r < 85) len = LEN_W'($urandom_range(5, MAX_PATTERN));
    else len = LEN_W'($urandom_range(31));
    if (ph == 2) len = LEN_W'(MAX_PATTERN);
    if (ph == 4) len = '1;                     // above the maximum, saturates
    if (ph == 6) len = '0;

    r = $urandom_range(99);
    if (r < 50) off = '0;
    else if (r < 80) off = OFFSET_W'($urandom_range(s));
    else off = OFFSET_W'($urandom_range(300));
    if (ph == 3) off = OFFSET_W'(DEPTH);
    if (ph == 5) off = OFFSET_W'($urandom_range(DEPTH + 1, 511));   // past the depth
    if (ph == 7) off = OFFSET_W'(DEPTH - 1);

    r = $urandom_range(99);
    if (r < 40) rng = RANGE_W'(DEPTH);
    else if (r < 70) rng = RANGE_W'($urandom_range(int'(len), 64));
    else rng = RANGE_W'($urandom_range(511));
    if (ph == 8) rng = '0;
    if (ph == 10) rng = '1;
    if (ph == 12) rng = RANGE_W'(1);

    write_reg(CFG_PATTERN_LOW, pat[63:0]);
    write_reg(CFG_PATTERN_HIGH, pat[127:64]);
    write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(len));
    write_reg(CFG_SEARCH_OFFSET, CFG_DATA_W'(off));
    write_reg(CFG_SEARCH_RANGE, CFG_DATA_W'(rng));
    write_reg(CFG_IGNORE_ZERO, CFG_DATA_W'(ign));
  endtask

  // driver: presents planned beats, holds start through busy, and runs the
  // predictor on each beat at the edge where it is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(ring_apply(SHADOW, cur_cmd));
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (op_backlog.size() != 0) begin
          // back to back beats keep start high, a single assignment per edge
          next_cmd = op_backlog.pop_front();
          cur_cmd <= next_cmd;
          operation <= next_cmd.op;
          data_in <= next_cmd.din;
          peek_offset <= next_cmd.poff;
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats cannot be held off, so take each one on its strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: ok %0d data_out %0h fill_level %0d",
               ok, data_out, fill_level);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          mismatch_count++;
        end
        if (data_out !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, data_out);
          mismatch_count++;
        end
        if (fill_level !== want.fill) begin
          $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
          mismatch_count++;
        end
        if (is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any beat on any channel ends the run
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int w = 0; w < 2; w++) begin
      ring_wr[w] = 0;
      ring_rd[w] = 0;
      ring_fill[w] = 0;
      for (int i = 0; i < DEPTH; i++) begin
        ring_mem[w][i] = '0;
        ring_seen[w][i] = 1'b0;
      end
    end
    // register values after reset
    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    win_offset = '0;
    win_range = RANGE_W'(DEPTH);
    skip_zero = 1'b1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, on the reset settings (empty pattern, full window)
    queue_simple(OP_POP);                          // pop on empty
    queue_simple(OP_SEARCH);                       // empty pattern on empty fifo hits
    queue_simple(OP_UNUSED_FIRST);
    queue_simple(OP_UNUSED_FIRST + 3'd1);
    queue_simple(OP_UNUSED_LAST);
    queue_cmd({OP_PUSH, 8'h00, 8'hff});
    queue_cmd({OP_PUSH, 8'hff, 8'h00});
    queue_cmd({OP_PUSH, 8'ha5, 8'h5a});
    queue_cmd({OP_PUSH, 8'h5a, 8'ha5});
    queue_cmd({OP_PEEK, 8'h00, 8'd0});
    queue_cmd({OP_PEEK, 8'hff, 8'd3});
    queue_simple(OP_SEARCH);
    queue_simple(OP_POP);
    queue_cmd({OP_PEEK, 8'h00, 8'd2});
    queue_simple(OP_CLEAR);
    queue_simple(OP_POP);                          // pop right after clear
    queue_cmd({OP_PEEK, 8'h00, 8'd3});             // stale byte beyond the fill
    queue_cmd({OP_PUSH, 8'h3c, 8'h00});
    queue_cmd({OP_PEEK, 8'h00, 8'd1});
    queue_simple(OP_SEARCH);
    queue_simple(OP_CLEAR);

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_idle();
      program_search(ph);
      no_gaps = (ph % 5 == 2);
      if (ph == FILL_PHASE) begin
        // fill to the top, then push into a full fifo
        while (ring_fill[PLAN] < DEPTH) begin
          if ($urandom_range(19) == 0) queue_simple(OP_SEARCH);
          else queue_simple(OP_PUSH);
        end
        repeat (6) queue_simple(OP_PUSH);
        repeat (3) queue_simple(OP_SEARCH);
        repeat (6) queue_peek();
      end else if (ph == DRAIN_PHASE) begin
        // empty it out, then pop on empty
        while (ring_fill[PLAN] > 0) begin
          if ($urandom_range(14) == 0) queue_simple(OP_SEARCH);
          else queue_simple(OP_POP);
        end
        repeat (4) queue_simple(OP_POP);
        queue_simple(OP_SEARCH);
        queue_peek();
      end else begin
        // odd phases lean to push, even to pop, so the fill wanders
        repeat (STEADY_ITEMS) begin
          if (ph % 2 == 1) queue_random(50, 25);
          else queue_random(25, 50);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
